@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each check runs on the rising clock
// edge and is held off while the asynchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP cache package
// Table size, header constants, status codes and the command and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

	localparam int TABLE_SIZE = 8;
	localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
	localparam int MAC_W      = 48;
	localparam int IP_W       = 32;
	localparam int ENTRY_W    = MAC_W + IP_W;

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(TABLE_SIZE);

	localparam logic [15:0] HW_ETHER   = 16'h0001;
	localparam logic [15:0] PROTO_IPV4 = 16'h0800;
	localparam logic [7:0]  IPV4_LEN   = 8'd4;
	localparam logic [15:0] OP_REQUEST = 16'h0001;
	localparam logic [15:0] OP_REPLY   = 16'h0002;
	localparam logic [7:0]  BCAST_BYTE = 8'hFF;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_HEADER = 1'b1;

	localparam logic [3:0] STAT_HIT       = 4'd0;
	localparam logic [3:0] STAT_MISS      = 4'd1;
	localparam logic [3:0] STAT_BAD_HW    = 4'd2;
	localparam logic [3:0] STAT_BAD_PROTO = 4'd3;
	localparam logic [3:0] STAT_BAD_LEN   = 4'd4;
	localparam logic [3:0] STAT_NOT_OURS  = 4'd5;
	localparam logic [3:0] STAT_ANSWERED  = 4'd6;
	localparam logic [3:0] STAT_LEARNED   = 4'd7;
	localparam logic [3:0] STAT_BAD_OP    = 4'd8;

	typedef struct packed {
		logic accept;
		logic rd_issue;
		logic hdr_eval;
		logic cap_lookup;
		logic load_out;
	} arpc_cmd_t;

	typedef struct packed {
		logic cnt_end;
		logic cmp_hit;
		logic cmp_last;
	} arpc_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/arpc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/arpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences one word at a time: table scan or header check, then hands the
// result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module arpc_ctrl
	import arpc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       cmd,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire arpc_stat_t stat,
	output arpc_cmd_t       ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_HDR  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.accept = 1'b1;
					state_d    = (cmd == CMD_LOOKUP) ? S_SCAN : S_HDR;
				end
			end
			S_SCAN: begin
				ctl.rd_issue = !stat.cnt_end;
				if (stat.cmp_hit || stat.cmp_last) begin
					ctl.cap_lookup = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_HDR: begin
				ctl.hdr_eval = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEXT(a_lookup_scans, in_valid && !in_stall && cmd == CMD_LOOKUP,
		state_q == S_SCAN, "accepted lookup did not start a scan")
	`ASSERT_SAME(a_no_overread, ctl.rd_issue, !stat.cnt_end,
		"table read issued past the last entry")
	`ASSERT_NEXT(a_capture_done, ctl.cap_lookup || ctl.hdr_eval,
		state_q == S_DONE && !ctl.accept, "result captured but not held")
	`ASSERT_NEXT(a_result_waits, state_q == S_DONE && out_valid_q && out_stall,
		state_q == S_DONE && out_valid_q, "pending result dropped while output stalled")

endmodule

`default_nettype wire

@@ rtl/core/arpc_dp.sv @@
// ----------------------------------------------------------------------------
// ARP cache datapath
// Holds the word in work, the address table, the round-robin write slot,
// the header checks and the result and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arpc_dp
	import arpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [IP_W-1:0]   cfg_wdata,
	input  wire logic [IP_W-1:0]   query_ip,
	input  wire logic [15:0]       hw_type,
	input  wire logic [15:0]       proto_type,
	input  wire logic [7:0]        proto_len,
	input  wire logic [15:0]       opcode,
	input  wire logic [MAC_W-1:0]  sender_mac,
	input  wire logic [IP_W-1:0]   sender_ip,
	input  wire logic [IP_W-1:0]   target_ip,
	input  wire arpc_cmd_t         ctl,
	output arpc_stat_t             stat,
	output logic [3:0]             status,
	output logic [MAC_W-1:0]       found_mac,
	output logic                   send_reply,
	output logic [MAC_W-1:0]       reply_target_mac,
	output logic [IP_W-1:0]        reply_target_ip,
	output logic                   resolved_valid,
	output logic [IP_W-1:0]        resolved_ip
);

	// Configuration and the word in work.
	logic [IP_W-1:0]  own_ip_q;
	logic [IP_W-1:0]  query_q;
	logic [15:0]      hw_q;
	logic [15:0]      proto_q;
	logic [7:0]       plen_q;
	logic [15:0]      op_q;
	logic [MAC_W-1:0] smac_q;
	logic [IP_W-1:0]  sip_q;
	logic [IP_W-1:0]  tip_q;

	// Table control.
	logic [TABLE_SIZE-1:0] valid_q;
	logic [IDX_W-1:0]      slot_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  rd_en_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic [ENTRY_W-1:0]    rd_data;
	logic [ENTRY_W-1:0]    rd_entry;
	logic                  match;

	// Header decision.
	logic [3:0]       hdr_status;
	logic             hdr_learn;
	logic             hdr_reply;
	logic             hdr_resolved;
	logic             wr_en;

	// Result held until the output register is free.
	logic [3:0]       res_status_q;
	logic [MAC_W-1:0] res_found_q;
	logic             res_reply_q;
	logic [MAC_W-1:0] res_rmac_q;
	logic [IP_W-1:0]  res_rip_q;
	logic             res_resv_q;
	logic [IP_W-1:0]  res_resip_q;

	arpc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(slot_q),
		.wdata({sip_q, smac_q}),
		.re   (ctl.rd_issue),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	// An entry never written still reads as its cleared value of zero.
	assign rd_entry = valid_q[rd_idx_s1] ? rd_data : '0;
	assign match    = (rd_entry[ENTRY_W-1:MAC_W] == query_q);

	assign stat.cnt_end  = (cnt_q == CNT_END);
	assign stat.cmp_hit  = rd_en_s1 && match;
	assign stat.cmp_last = rd_en_s1 && (rd_idx_s1 == LAST_IDX);

	always_comb begin
		hdr_status   = STAT_BAD_OP;
		hdr_learn    = 1'b0;
		hdr_reply    = 1'b0;
		hdr_resolved = 1'b0;
		if (hw_q != HW_ETHER) begin
			hdr_status = STAT_BAD_HW;
		end else if (proto_q != PROTO_IPV4) begin
			hdr_status = STAT_BAD_PROTO;
		end else if (plen_q != IPV4_LEN) begin
			hdr_status = STAT_BAD_LEN;
		end else if (op_q == OP_REQUEST) begin
			if (tip_q != own_ip_q) begin
				hdr_status = STAT_NOT_OURS;
			end else begin
				hdr_status = STAT_ANSWERED;
				hdr_learn  = 1'b1;
				hdr_reply  = 1'b1;
			end
		end else if (op_q == OP_REPLY) begin
			hdr_status   = STAT_LEARNED;
			hdr_learn    = 1'b1;
			hdr_resolved = 1'b1;
		end
	end

	assign wr_en = ctl.hdr_eval && hdr_learn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
			valid_q  <= '0;
			slot_q   <= '0;
			cnt_q    <= '0;
			rd_en_s1 <= 1'b0;
		end else begin
			if (cfg_wen) begin
				own_ip_q <= cfg_wdata;
			end
			if (ctl.accept) begin
				cnt_q <= '0;
			end else if (ctl.rd_issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			rd_en_s1 <= ctl.rd_issue;
			if (wr_en) begin
				valid_q[slot_q] <= 1'b1;
				slot_q          <= (slot_q == LAST_IDX) ? '0 : slot_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			query_q <= query_ip;
			hw_q    <= hw_type;
			proto_q <= proto_type;
			plen_q  <= proto_len;
			op_q    <= opcode;
			smac_q  <= sender_mac;
			sip_q   <= sender_ip;
			tip_q   <= target_ip;
		end
		rd_idx_s1 <= cnt_q[IDX_W-1:0];
		if (ctl.cap_lookup) begin
			res_status_q <= stat.cmp_hit ? STAT_HIT : STAT_MISS;
			res_found_q  <= stat.cmp_hit ? rd_entry[MAC_W-1:0] : '0;
			res_reply_q  <= 1'b0;
			res_rmac_q   <= '0;
			res_rip_q    <= '0;
			res_resv_q   <= 1'b0;
			res_resip_q  <= '0;
		end else if (ctl.hdr_eval) begin
			res_status_q <= hdr_status;
			res_found_q  <= '0;
			res_reply_q  <= hdr_reply;
			// A broadcast-looking sender hardware address is answered with zero.
			res_rmac_q   <= (hdr_reply && smac_q[MAC_W-1:MAC_W-8] != BCAST_BYTE) ?
				smac_q : '0;
			res_rip_q    <= hdr_reply ? sip_q : '0;
			res_resv_q   <= hdr_resolved;
			res_resip_q  <= hdr_resolved ? sip_q : '0;
		end
		if (ctl.load_out) begin
			status           <= res_status_q;
			found_mac        <= res_found_q;
			send_reply       <= res_reply_q;
			reply_target_mac <= res_rmac_q;
			reply_target_ip  <= res_rip_q;
			resolved_valid   <= res_resv_q;
			resolved_ip      <= res_resip_q;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/arp_cache_engine.sv @@
// Takes one word at a time, either a lookup (cmd 0) or a parsed ARP header
// (cmd 1), and returns one result word for each. A header is checked in the
// state after the one that accepts it, and its result is then loaded into the
// output register; the next word can be accepted in the cycle after that.
// A lookup reads the table one entry per cycle through its single read port.
// It stops at the first matching entry or, on a miss, after the last entry,
// and its result is then loaded, followed by the idle state for the next word.
// The input is stalled while a word is in work. A finished result waits in the
// output register while the next word is accepted. If that register still holds
// a word that has not been taken, the next result waits for it and the input
// stays stalled. The own address register may be written at any idle time and
// resets to zero.
// ----------------------------------------------------------------------------
// ARP cache engine
// IPv4 address cache with header checking, learning and round-robin
// replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_engine
	import arpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [IP_W-1:0]   cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              cmd,
	input  wire logic [IP_W-1:0]   query_ip,
	input  wire logic [15:0]       hw_type,
	input  wire logic [15:0]       proto_type,
	input  wire logic [7:0]        proto_len,
	input  wire logic [15:0]       opcode,
	input  wire logic [MAC_W-1:0]  sender_mac,
	input  wire logic [IP_W-1:0]   sender_ip,
	input  wire logic [IP_W-1:0]   target_ip,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [3:0]             status,
	output logic [MAC_W-1:0]       found_mac,
	output logic                   send_reply,
	output logic [MAC_W-1:0]       reply_target_mac,
	output logic [IP_W-1:0]        reply_target_ip,
	output logic                   resolved_valid,
	output logic [IP_W-1:0]        resolved_ip
);

	arpc_cmd_t  ctl;
	arpc_stat_t stat;

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	arpc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_wdata       (cfg_wdata),
		.query_ip        (query_ip),
		.hw_type         (hw_type),
		.proto_type      (proto_type),
		.proto_len       (proto_len),
		.opcode          (opcode),
		.sender_mac      (sender_mac),
		.sender_ip       (sender_ip),
		.target_ip       (target_ip),
		.ctl             (ctl),
		.stat            (stat),
		.status          (status),
		.found_mac       (found_mac),
		.send_reply      (send_reply),
		.reply_target_mac(reply_target_mac),
		.reply_target_ip (reply_target_ip),
		.resolved_valid  (resolved_valid),
		.resolved_ip     (resolved_ip)
	);

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache engine testbench
// Sends lookups and parsed ARP headers through the valid/stall input channel.
// Each accepted word is run through a behavioral copy of the cache table, and
// the result is queued. Every result word is then checked field by field
// against the oldest queued result. Both sides idle at random, and the result
// side holds off for a long stretch once. The own address is changed between
// phases.
// ----------------------------------------------------------------------------

module testbench;
	import arpc_pkg::*;

	localparam int POOL_SIZE      = 12;
	localparam int LONG_HOLD      = 80;
	localparam int DRAIN_CYCLES   = TABLE_SIZE + 8;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic             cmd;
		logic [IP_W-1:0]  query_ip;
		logic [15:0]      hw_type;
		logic [15:0]      proto_type;
		logic [7:0]       proto_len;
		logic [15:0]      opcode;
		logic [MAC_W-1:0] sender_mac;
		logic [IP_W-1:0]  sender_ip;
		logic [IP_W-1:0]  target_ip;
	} arp_word_t;

	typedef struct packed {
		logic [3:0]       status;
		logic [MAC_W-1:0] found_mac;
		logic             send_reply;
		logic [MAC_W-1:0] reply_target_mac;
		logic [IP_W-1:0]  reply_target_ip;
		logic             resolved_valid;
		logic [IP_W-1:0]  resolved_ip;
	} arp_result_t;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             cfg_wen    = 1'b0;
	logic [IP_W-1:0]  cfg_wdata  = '0;
	logic             in_valid   = 1'b0;
	logic             in_stall;
	logic             cmd        = 1'b0;
	logic [IP_W-1:0]  query_ip   = '0;
	logic [15:0]      hw_type    = '0;
	logic [15:0]      proto_type = '0;
	logic [7:0]       proto_len  = '0;
	logic [15:0]      opcode     = '0;
	logic [MAC_W-1:0] sender_mac = '0;
	logic [IP_W-1:0]  sender_ip  = '0;
	logic [IP_W-1:0]  target_ip  = '0;
	logic             out_valid;
	logic             out_stall  = 1'b0;
	logic [3:0]       status;
	logic [MAC_W-1:0] found_mac;
	logic             send_reply;
	logic [MAC_W-1:0] reply_target_mac;
	logic [IP_W-1:0]  reply_target_ip;
	logic             resolved_valid;
	logic [IP_W-1:0]  resolved_ip;

	// Behavioral copy of the cache state.
	logic [IP_W-1:0]  cache_ip  [TABLE_SIZE];
	logic [MAC_W-1:0] cache_mac [TABLE_SIZE];
	int               next_slot;
	logic [IP_W-1:0]  own_addr;

	arp_result_t      pending_results[$];
	logic [IP_W-1:0]  addr_pool[POOL_SIZE];
	int               status_seen[16];
	int               mismatches     = 0;
	int               words_sent     = 0;
	int               results_seen   = 0;
	int               addr_settings  = 0;
	int               quiet_cycles   = 0;
	bit               tx_idle_en     = 1'b0;
	bit               rx_idle_en     = 1'b0;
	bit               hold_req       = 1'b0;

	arp_cache_engine u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wen          (cfg_wen),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.query_ip         (query_ip),
		.hw_type          (hw_type),
		.proto_type       (proto_type),
		.proto_len        (proto_len),
		.opcode           (opcode),
		.sender_mac       (sender_mac),
		.sender_ip        (sender_ip),
		.target_ip        (target_ip),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.found_mac        (found_mac),
		.send_reply       (send_reply),
		.reply_target_mac (reply_target_mac),
		.reply_target_ip  (reply_target_ip),
		.resolved_valid   (resolved_valid),
		.resolved_ip      (resolved_ip)
	);

	always #2 clk = ~clk;

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return bits[MAC_W-1:0];
	endfunction

	function automatic void learn_entry(logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip);
		cache_ip[next_slot]  = ip;
		cache_mac[next_slot] = mac;
		next_slot = (next_slot == TABLE_SIZE - 1) ? 0 : next_slot + 1;
	endfunction

	// Computes the result of one word and updates the cache copy.
	function automatic arp_result_t arp_cache_predict(arp_word_t w);
		arp_result_t r;
		r = '0;
		if (w.cmd == CMD_LOOKUP) begin
			r.status = STAT_MISS;
			// Walk downward so the lowest matching index is the one kept.
			for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
				if (cache_ip[i] == w.query_ip) begin
					r.status    = STAT_HIT;
					r.found_mac = cache_mac[i];
				end
			end
		end else if (w.hw_type != HW_ETHER) begin
			r.status = STAT_BAD_HW;
		end else if (w.proto_type != PROTO_IPV4) begin
			r.status = STAT_BAD_PROTO;
		end else if (w.proto_len != IPV4_LEN) begin
			r.status = STAT_BAD_LEN;
		end else if (w.opcode == OP_REQUEST) begin
			if (w.target_ip != own_addr) begin
				r.status = STAT_NOT_OURS;
			end else begin
				learn_entry(w.sender_mac, w.sender_ip);
				r.status           = STAT_ANSWERED;
				r.send_reply       = 1'b1;
				r.reply_target_mac = (w.sender_mac[MAC_W-1 -: 8] == BCAST_BYTE) ?
					'0 : w.sender_mac;
				r.reply_target_ip  = w.sender_ip;
			end
		end else if (w.opcode == OP_REPLY) begin
			learn_entry(w.sender_mac, w.sender_ip);
			r.status         = STAT_LEARNED;
			r.resolved_valid = 1'b1;
			r.resolved_ip    = w.sender_ip;
		end else begin
			r.status = STAT_BAD_OP;
		end
		status_seen[r.status]++;
		return r;
	endfunction

	function automatic arp_word_t lookup_word(logic [IP_W-1:0] ip);
		arp_word_t w;
		w.cmd        = CMD_LOOKUP;
		w.query_ip   = ip;
		w.hw_type    = 16'($urandom());
		w.proto_type = 16'($urandom());
		w.proto_len  = 8'($urandom());
		w.opcode     = 16'($urandom());
		w.sender_mac = rand_mac();
		w.sender_ip  = $urandom();
		w.target_ip  = $urandom();
		return w;
	endfunction

	function automatic arp_word_t header_word(logic [15:0] hw, logic [15:0] proto,
			logic [7:0] len, logic [15:0] op, logic [MAC_W-1:0] smac,
			logic [IP_W-1:0] sip, logic [IP_W-1:0] tip);
		arp_word_t w;
		w.cmd        = CMD_HEADER;
		w.query_ip   = $urandom();
		w.hw_type    = hw;
		w.proto_type = proto;
		w.proto_len  = len;
		w.opcode     = op;
		w.sender_mac = smac;
		w.sender_ip  = sip;
		w.target_ip  = tip;
		return w;
	endfunction

	function automatic logic [IP_W-1:0] pick_ip();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (r < 8)
			return own_addr;
		return $urandom();
	endfunction

	// Mostly well-formed lookups, requests and replies, with some broken headers.
	function automatic arp_word_t random_word();
		arp_word_t w;
		logic [MAC_W-1:0] smac;
		int r;
		r    = $urandom_range(0, 99);
		smac = rand_mac();
		if ($urandom_range(0, 7) == 0)
			smac[MAC_W-1 -: 8] = BCAST_BYTE;
		if (r < 30) begin
			w = lookup_word(($urandom_range(0, 19) == 0) ? '0 : pick_ip());
		end else if (r < 55) begin
			w = header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN, OP_REPLY, smac, pick_ip(),
				$urandom());
		end else if (r < 80) begin
			w = header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN, OP_REQUEST, smac, pick_ip(),
				($urandom_range(0, 4) != 0) ? own_addr : pick_ip());
		end else begin
			w = header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN,
				($urandom_range(0, 1) != 0) ? OP_REQUEST : OP_REPLY, smac, pick_ip(),
				own_addr);
			if ($urandom_range(0, 2) == 0) w.hw_type    = 16'($urandom());
			if ($urandom_range(0, 2) == 0) w.proto_type = 16'($urandom());
			if ($urandom_range(0, 2) == 0) w.proto_len  = 8'($urandom());
			if ($urandom_range(0, 2) == 0) w.opcode     = 16'($urandom());
			if ($urandom_range(0, 3) == 0) w.target_ip  = $urandom();
		end
		return w;
	endfunction

	task automatic send_word(input arp_word_t w);
		int gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd        <= w.cmd;
		query_ip   <= w.query_ip;
		hw_type    <= w.hw_type;
		proto_type <= w.proto_type;
		proto_len  <= w.proto_len;
		opcode     <= w.opcode;
		sender_mac <= w.sender_mac;
		sender_ip  <= w.sender_ip;
		target_ip  <= w.target_ip;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(arp_cache_predict(w));
		words_sent++;
	endtask

	// Lets every expected result come out, then waits for the work in flight to settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_own_ip(input logic [IP_W-1:0] addr);
		wait_idle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		own_addr = addr;
		addr_settings++;
	endtask

	task automatic test_zeroed_table();
		send_word(lookup_word('0));
		send_word(lookup_word('1));
		send_word(lookup_word(32'h0000_0001));
	endtask

	task automatic test_header_checks();
		set_own_ip(32'hC0A8_0001);
		send_word(header_word(16'h0000, 16'hFFFF, 8'h00, 16'h0000, '1, '1, own_addr));
		send_word(header_word(16'hFFFF, PROTO_IPV4, IPV4_LEN, OP_REPLY, '1, '1, own_addr));
		send_word(header_word(HW_ETHER, 16'h0806, 8'h06, OP_REQUEST, '0, '0, own_addr));
		send_word(header_word(HW_ETHER, 16'hFFFF, IPV4_LEN, OP_REPLY, '0, '0, own_addr));
		send_word(header_word(HW_ETHER, PROTO_IPV4, 8'h00, 16'h0000, '0, '0, own_addr));
		send_word(header_word(HW_ETHER, PROTO_IPV4, 8'hFF, OP_REQUEST, '0, '0, own_addr));
		send_word(header_word(HW_ETHER, PROTO_IPV4, 8'h06, OP_REPLY, '0, '0, own_addr));
		send_word(header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN, 16'h0000, '1, '1, own_addr));
		send_word(header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN, 16'h0003, '1, '1, own_addr));
		send_word(header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN, 16'hFFFF, '1, '1, own_addr));
	endtask

	task automatic test_requests();
		send_word(header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN, OP_REQUEST,
			48'h0011_2233_4455, 32'h0A00_0001, '1));
		// A sender address with a broadcast first byte is not echoed in the reply.
		send_word(header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN, OP_REQUEST,
			48'hFF00_0000_0001, 32'h0A00_0002, own_addr));
		send_word(header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN, OP_REQUEST,
			48'h00AB_CDEF_0123, 32'h0A00_0003, own_addr));
		send_word(lookup_word(32'h0A00_0003));
		set_own_ip('1);
		send_word(header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN, OP_REQUEST,
			'1, '1, own_addr));
	endtask

	task automatic test_replies();
		// The same address learned twice: the older, lower entry answers lookups.
		send_word(header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN, OP_REPLY,
			48'h0200_0000_0001, 32'h0A00_0010, '0));
		send_word(header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN, OP_REPLY,
			48'h0200_0000_0002, 32'h0A00_0010, '0));
		send_word(lookup_word(32'h0A00_0010));
		send_word(header_word(HW_ETHER, PROTO_IPV4, IPV4_LEN, OP_REPLY,
			48'h5555_AAAA_5555, '0, '1));
		send_word(lookup_word('0));
	endtask

	task automatic test_random_traffic(input int count, input bit tx_idle, input bit rx_idle);
		tx_idle_en = tx_idle;
		rx_idle_en = rx_idle;
		for (int i = 0; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom();
		repeat (count) send_word(random_word());
	endtask

	// The result side holds off long enough for the engine to back up its input.
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		hold_req   = 1'b1;
		repeat (24) send_word(random_word());
	endtask

	initial begin
		for (int i = 0; i < TABLE_SIZE; i++) begin
			cache_ip[i]  = '0;
			cache_mac[i] = '0;
		end
		next_slot = 0;
		own_addr  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zeroed_table();
		test_header_checks();
		test_requests();
		test_replies();
		test_random_traffic(700, 1'b1, 1'b1);
		set_own_ip($urandom());
		test_backpressure();
		test_random_traffic(300, 1'b1, 1'b0);
		set_own_ip('0);
		test_random_traffic(500, 1'b0, 1'b1);
		set_own_ip($urandom());
		test_random_traffic(350, 1'b1, 1'b1);
		test_random_traffic(150, 1'b0, 1'b0);
		wait_idle();

		$display("Covered %0d words and %0d results under %0d own addresses.",
			words_sent, results_seen, addr_settings + 1);
		$display("Lookups %0d hit, %0d miss; %0d answered, %0d learned, %0d rejected.",
			status_seen[STAT_HIT], status_seen[STAT_MISS], status_seen[STAT_ANSWERED],
			status_seen[STAT_LEARNED], status_seen[STAT_BAD_HW] + status_seen[STAT_BAD_PROTO]
			+ status_seen[STAT_BAD_LEN] + status_seen[STAT_NOT_OURS]
			+ status_seen[STAT_BAD_OP]);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Result side: random short stalls, or one long hold when asked.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		arp_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t ns: result word with none expected, status %0d", $time, status);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 64'(want.status), 64'(status));
				check_field("found_mac", 64'(want.found_mac), 64'(found_mac));
				check_field("send_reply", 64'(want.send_reply), 64'(send_reply));
				check_field("reply_target_mac", 64'(want.reply_target_mac),
					64'(reply_target_mac));
				check_field("reply_target_ip", 64'(want.reply_target_ip),
					64'(reply_target_ip));
				check_field("resolved_valid", 64'(want.resolved_valid), 64'(resolved_valid));
				check_field("resolved_ip", 64'(want.resolved_ip), 64'(resolved_ip));
			end
		end
	end

	// Ends the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/arpc_pkg.sv
rtl/core/arpc_ram.sv
rtl/core/arpc_ctrl.sv
rtl/core/arpc_dp.sv
rtl/core/arp_cache_engine.sv
tb/testbench.sv
